[rtl/stq_pkg.sv]
// shared constants, types and the wrap compare of the sorted timer queue
package stq_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_RES   = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int NRES_W    = $clog2(MAX_RES + 1);
    localparam int ID_W      = 4;
    localparam int REQ_W     = 2;
    localparam int PORT_T_W  = 32;

    localparam logic [REQ_W-1:0] REQ_ADD_ONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_PER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    function automatic logic is_later(input t_time a, input t_time b);
        t_time d;
        d = a - b;
        return (d != '0) && !d[TIME_BITS-1];
    endfunction

endpackage

[rtl/stq_ram.sv]
// simple dual-port ram with registered read data
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sorted_timer_queue.sv]
// top level of the sorted timer queue: request sequencer over the order, due and period rams
// Takes one request word at a time and holds o_stall high until its work is done. The queue
// order, due times and periods sit in rams with registered read data, so every step is a
// ram read followed by a compare or a write. An add scans the queued entries for its place
// and shifts the entries behind it; a re-add or delete first finds the timer by scanning
// and closes the gap behind it. A tick checks the head and expires it, pops the head and,
// for a periodic timer, walks the queue again to re-insert it. Expiry words go out through
// an output register, so a stall on the output only holds the tick that is producing them.
module sorted_timer_queue
    import stq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ID_W-1:0]     i_timer_id,
    input  logic [PORT_T_W-1:0] i_interval,
    input  logic [PORT_T_W-1:0] i_time_now,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ID_W-1:0]     o_expired_id,
    output logic [PORT_T_W-1:0] o_due_time,
    output logic                o_is_periodic,
    output logic                o_last_expiry
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RM_RD    = 5'd1;
    localparam logic [4:0] S_RM_CMP   = 5'd2;
    localparam logic [4:0] S_RM_SH_RD = 5'd3;
    localparam logic [4:0] S_RM_SH_WR = 5'd4;
    localparam logic [4:0] S_IN_RD    = 5'd5;
    localparam logic [4:0] S_IN_RD2   = 5'd6;
    localparam logic [4:0] S_IN_CMP   = 5'd7;
    localparam logic [4:0] S_IN_SH_RD = 5'd8;
    localparam logic [4:0] S_IN_SH_WR = 5'd9;
    localparam logic [4:0] S_ADD_WR   = 5'd10;
    localparam logic [4:0] S_DEL_WR   = 5'd11;
    localparam logic [4:0] S_TK_HEAD  = 5'd12;
    localparam logic [4:0] S_TK_RD2   = 5'd13;
    localparam logic [4:0] S_TK_CMP   = 5'd14;
    localparam logic [4:0] S_TK_PUSH  = 5'd15;
    localparam logic [4:0] S_TK_AFTER = 5'd16;
    localparam logic [4:0] S_TK_END   = 5'd17;

    logic [4:0]          r_state, n_state;
    logic [4:0]          r_ret, n_ret;
    t_cnt                r_count, n_count;
    t_cnt                r_pos, n_pos;
    t_cnt                r_k, n_k;
    logic [SLOTS-1:0]    r_armed, n_armed;
    logic [SLOTS-1:0]    r_fired, n_fired;
    logic                r_first, n_first;
    logic [NRES_W-1:0]   r_nres, n_nres;
    logic [REQ_W-1:0]    r_req, n_req;
    t_slot               r_id, n_id;
    t_time               r_iv, n_iv;
    t_time               r_now, n_now;
    t_time               r_due_new, n_due_new;
    t_time               r_hdue, n_hdue;
    t_time               r_hper, n_hper;
    logic                r_hold_valid, n_hold_valid;
    t_slot               r_hold_id, n_hold_id;
    t_time               r_hold_due, n_hold_due;
    logic                r_hold_per, n_hold_per;
    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [PORT_T_W-1:0] r_out_due, n_out_due;
    logic                r_out_per, n_out_per;
    logic                r_out_last, n_out_last;

    logic  ord_we;
    t_slot ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic  due_we, per_we;
    t_slot tim_waddr, tim_raddr;
    t_time due_wdata, per_wdata, due_rdata, per_rdata;

    logic  accept, out_free, in_range;
    t_slot in_slot;
    t_time in_iv, in_now;

    stq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    stq_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_due (
        .i_clk(i_clk), .i_we(due_we), .i_waddr(tim_waddr), .i_wdata(due_wdata),
        .i_raddr(tim_raddr), .o_rdata(due_rdata)
    );

    stq_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_period (
        .i_clk(i_clk), .i_we(per_we), .i_waddr(tim_waddr), .i_wdata(per_wdata),
        .i_raddr(tim_raddr), .o_rdata(per_rdata)
    );

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign in_range = (32'(i_timer_id) < SLOTS);
    assign in_slot  = SLOT_W'(i_timer_id);
    assign in_now   = TIME_BITS'(i_time_now);
    assign in_iv    = (TIME_BITS'(i_interval) == '0) ? TIME_BITS'(1) : TIME_BITS'(i_interval);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_count      = r_count;
        n_pos        = r_pos;
        n_k          = r_k;
        n_armed      = r_armed;
        n_fired      = r_fired;
        n_first      = r_first;
        n_nres       = r_nres;
        n_req        = r_req;
        n_id         = r_id;
        n_iv         = r_iv;
        n_now        = r_now;
        n_due_new    = r_due_new;
        n_hdue       = r_hdue;
        n_hper       = r_hper;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_hold_due   = r_hold_due;
        n_hold_per   = r_hold_per;
        n_out_valid  = r_out_valid && i_stall;
        n_out_id     = r_out_id;
        n_out_due    = r_out_due;
        n_out_per    = r_out_per;
        n_out_last   = r_out_last;

        ord_we    = 1'b0;
        ord_waddr = SLOT_W'(r_pos);
        ord_wdata = ord_rdata;
        ord_raddr = SLOT_W'(r_pos);
        due_we    = 1'b0;
        per_we    = 1'b0;
        tim_waddr = r_id;
        tim_raddr = ord_rdata;
        due_wdata = r_due_new;
        per_wdata = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req     = i_req_type;
                    n_id      = in_slot;
                    n_iv      = in_iv;
                    n_now     = in_now;
                    n_due_new = in_now + in_iv;
                    n_pos     = '0;
                    case (i_req_type) inside
                        REQ_ADD_ONE, REQ_ADD_PER: begin
                            if (in_range) begin
                                n_ret   = S_ADD_WR;
                                n_state = r_armed[in_slot] ? S_RM_RD : S_ADD_WR;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_range) begin
                                n_ret   = S_DEL_WR;
                                n_state = r_armed[in_slot] ? S_RM_RD : S_DEL_WR;
                            end
                        end
                        default: begin
                            if (r_first) begin
                                n_first = 1'b0;
                            end else begin
                                n_fired = '0;
                                n_nres  = '0;
                                n_state = S_TK_HEAD;
                            end
                        end
                    endcase
                end
            end
            S_RM_RD: begin
                ord_raddr = SLOT_W'(r_pos);
                n_state   = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (ord_rdata == r_id) begin
                    n_state = S_RM_SH_RD;
                end else if (r_pos + CNT_W'(1) >= r_count) begin
                    n_state = r_ret;
                end else begin
                    n_pos   = r_pos + CNT_W'(1);
                    n_state = S_RM_RD;
                end
            end
            S_RM_SH_RD: begin
                if (r_pos + CNT_W'(1) < r_count) begin
                    ord_raddr = SLOT_W'(r_pos + CNT_W'(1));
                    n_state   = S_RM_SH_WR;
                end else begin
                    n_count       = r_count - CNT_W'(1);
                    n_armed[r_id] = 1'b0;
                    n_state       = r_ret;
                end
            end
            S_RM_SH_WR: begin
                ord_we    = 1'b1;
                ord_waddr = SLOT_W'(r_pos);
                ord_wdata = ord_rdata;
                n_pos     = r_pos + CNT_W'(1);
                n_state   = S_RM_SH_RD;
            end
            S_ADD_WR: begin
                due_we    = 1'b1;
                per_we    = 1'b1;
                due_wdata = r_due_new;
                per_wdata = (r_req == REQ_ADD_PER) ? r_iv : '0;
                n_pos     = '0;
                n_ret     = S_IDLE;
                n_state   = S_IN_RD;
            end
            S_DEL_WR: begin
                due_we    = 1'b1;
                per_we    = 1'b1;
                due_wdata = '0;
                per_wdata = '0;
                n_state   = S_IDLE;
            end
            S_IN_RD: begin
                if (r_count == CNT_W'(SLOTS)) begin
                    n_state = r_ret;
                end else if (r_pos == r_count) begin
                    n_k     = r_count;
                    n_state = S_IN_SH_RD;
                end else begin
                    ord_raddr = SLOT_W'(r_pos);
                    n_state   = S_IN_RD2;
                end
            end
            S_IN_RD2: begin
                tim_raddr = ord_rdata;
                n_state   = S_IN_CMP;
            end
            S_IN_CMP: begin
                if (is_later(due_rdata, r_due_new)) begin
                    n_k     = r_count;
                    n_state = S_IN_SH_RD;
                end else begin
                    n_pos   = r_pos + CNT_W'(1);
                    n_state = S_IN_RD;
                end
            end
            S_IN_SH_RD: begin
                if (r_k > r_pos) begin
                    ord_raddr = SLOT_W'(r_k - CNT_W'(1));
                    n_state   = S_IN_SH_WR;
                end else begin
                    ord_we        = 1'b1;
                    ord_waddr     = SLOT_W'(r_pos);
                    ord_wdata     = r_id;
                    n_count       = r_count + CNT_W'(1);
                    n_armed[r_id] = 1'b1;
                    n_state       = r_ret;
                end
            end
            S_IN_SH_WR: begin
                ord_we    = 1'b1;
                ord_waddr = SLOT_W'(r_k);
                ord_wdata = ord_rdata;
                n_k       = r_k - CNT_W'(1);
                n_state   = S_IN_SH_RD;
            end
            S_TK_HEAD: begin
                if (r_count == '0 || r_nres == NRES_W'(MAX_RES)) begin
                    n_state = S_TK_END;
                end else begin
                    ord_raddr = '0;
                    n_state   = S_TK_RD2;
                end
            end
            S_TK_RD2: begin
                tim_raddr = ord_rdata;
                n_id      = ord_rdata;
                n_state   = S_TK_CMP;
            end
            S_TK_CMP: begin
                n_hdue = due_rdata;
                n_hper = per_rdata;
                if (is_later(due_rdata, r_now) || r_fired[r_id]) begin
                    n_state = S_TK_END;
                end else begin
                    n_state = S_TK_PUSH;
                end
            end
            S_TK_PUSH: begin
                if (!r_hold_valid || out_free) begin
                    if (r_hold_valid) begin
                        n_out_valid = 1'b1;
                        n_out_id    = ID_W'(r_hold_id);
                        n_out_due   = PORT_T_W'(r_hold_due);
                        n_out_per   = r_hold_per;
                        n_out_last  = 1'b0;
                    end
                    n_hold_valid  = 1'b1;
                    n_hold_id     = r_id;
                    n_hold_due    = r_hdue;
                    n_hold_per    = (r_hper != '0);
                    n_fired[r_id] = 1'b1;
                    n_nres        = r_nres + NRES_W'(1);
                    n_pos         = '0;
                    n_ret         = S_TK_AFTER;
                    n_state       = S_RM_SH_RD;
                end
            end
            S_TK_AFTER: begin
                if (r_hper != '0) begin
                    due_we    = 1'b1;
                    due_wdata = r_now + r_hper;
                    n_due_new = r_now + r_hper;
                    n_pos     = '0;
                    n_ret     = S_TK_HEAD;
                    n_state   = S_IN_RD;
                end else begin
                    n_state = S_TK_HEAD;
                end
            end
            S_TK_END: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = ID_W'(r_hold_id);
                    n_out_due    = PORT_T_W'(r_hold_due);
                    n_out_per    = r_hold_per;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_count      <= '0;
            r_armed      <= '0;
            r_fired      <= '0;
            r_first      <= 1'b1;
            r_nres       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_count      <= n_count;
            r_armed      <= n_armed;
            r_fired      <= n_fired;
            r_first      <= n_first;
            r_nres       <= n_nres;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_req      <= n_req;
        r_id       <= n_id;
        r_iv       <= n_iv;
        r_now      <= n_now;
        r_due_new  <= n_due_new;
        r_hdue     <= n_hdue;
        r_hper     <= n_hper;
        r_hold_id  <= n_hold_id;
        r_hold_due <= n_hold_due;
        r_hold_per <= n_hold_per;
        r_out_id   <= n_out_id;
        r_out_due  <= n_out_due;
        r_out_per  <= n_out_per;
        r_out_last <= n_out_last;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_expired_id  = r_out_id;
    assign o_due_time    = r_out_due;
    assign o_is_periodic = r_out_per;
    assign o_last_expiry = r_out_last;

endmodule

[dv/sorted_timer_queue_tb.sv]
// self-checking testbench of the sorted timer queue: directed table, then random requests
`timescale 1ns / 100ps

module sorted_timer_queue_tb;
    import stq_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PORT_T_W-1:0] due;
        logic                per;
        logic                last;
    } t_expiry;

    typedef struct {
        logic [REQ_W-1:0]    req;
        logic [ID_W-1:0]     id;
        logic [PORT_T_W-1:0] ival;
        logic [PORT_T_W-1:0] now;
        int                  n_typed;
        t_expiry             typed;
    } t_row;

    logic                i_clk, i_rst_n, i_valid, i_stall;
    logic                o_stall, o_valid, o_is_periodic, o_last_expiry;
    logic [REQ_W-1:0]    i_req_type;
    logic [ID_W-1:0]     i_timer_id;
    logic [PORT_T_W-1:0] i_interval, i_time_now, o_due_time;
    logic [ID_W-1:0]     o_expired_id;

    sorted_timer_queue i_dut (.*);

    // predictor state
    logic [SLOT_W-1:0] q_order[SLOTS];
    int                q_count;
    t_time             due_of[SLOTS];
    t_time             period_of[SLOTS];
    logic              armed[SLOTS];
    logic              tick_skip;

    t_expiry expected_q[$];
    int      mismatches, watchdog;
    t_time   clock_now;
    t_expiry got, want;

    function automatic bit later(t_time a, t_time b);
        t_time d;
        d = a - b;
        return d != '0 && !d[TIME_BITS-1];
    endfunction

    function automatic void unlink(int id);
        int p;
        p = -1;
        for (int i = 0; i < q_count; i++)
            if (p < 0 && q_order[i] == id) p = i;
        if (p < 0) return;
        for (int i = p; i + 1 < q_count; i++) q_order[i] = q_order[i+1];
        q_count--;
        q_order[q_count] = '0;
        armed[id] = 1'b0;
    endfunction

    function automatic void link(int id);
        int p;
        p = q_count;
        if (q_count >= SLOTS) return;
        for (int i = 0; i < q_count; i++)
            if (p == q_count && later(due_of[q_order[i]], due_of[id])) p = i;
        for (int i = q_count; i > p; i--) q_order[i] = q_order[i-1];
        q_order[p] = SLOT_W'(id);
        q_count++;
        armed[id] = 1'b1;
    endfunction

    function automatic void predict_expiries(t_row r);
        t_time   iv;
        bit      fired[SLOTS];
        int      h, n;
        t_expiry e;
        iv = (r.ival == '0) ? t_time'(1) : r.ival;
        n = 0;
        if (r.req == REQ_ADD_ONE || r.req == REQ_ADD_PER) begin
            if (armed[r.id]) unlink(r.id);
            due_of[r.id] = r.now + iv;
            period_of[r.id] = (r.req == REQ_ADD_PER) ? iv : '0;
            link(r.id);
        end else if (r.req == REQ_DELETE) begin
            if (armed[r.id]) unlink(r.id);
            due_of[r.id] = '0;
            period_of[r.id] = '0;
        end else if (tick_skip) begin
            tick_skip = 1'b0;
        end else begin
            foreach (fired[i]) fired[i] = 1'b0;
            while (n < MAX_RES && q_count > 0) begin
                h = q_order[0];
                if (later(due_of[h], r.now) || fired[h]) break;
                unlink(h);
                fired[h] = 1'b1;
                e.id = ID_W'(h); e.due = due_of[h]; e.per = period_of[h] != '0; e.last = 1'b0;
                expected_q.push_back(e);
                n++;
                if (period_of[h] != '0) begin
                    due_of[h] = r.now + period_of[h];
                    link(h);
                end
            end
            if (n > 0) expected_q[$].last = 1'b1;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    task automatic send(t_row r);
        int t_before;
        repeat (gap()) @(negedge i_clk);
        i_req_type = r.req; i_timer_id = r.id; i_interval = r.ival; i_time_now = r.now;
        i_valid = 1'b1;
        t_before = expected_q.size();
        predict_expiries(r);
        if (r.n_typed == 0 && expected_q.size() != t_before) begin
            if (mismatches < 10)
                $display("table row expects 0 expiries, predictor made %0d",
                         expected_q.size() - t_before);
            mismatches++;
        end else if (r.n_typed == 1 && (expected_q.size() != t_before + 1
                     || expected_q[$] != r.typed)) begin
            if (mismatches < 10) $display("table row expiry %p differs from predictor %p",
                                          r.typed, expected_q[$]);
            mismatches++;
        end
        // o_stall is stable at the falling edge; low means the word goes in at the next rise
        while (o_stall) @(negedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic t_row mk(logic [REQ_W-1:0] q, int id, t_time iv, t_time now);
        t_row r;
        r.req = q; r.id = ID_W'(id); r.ival = iv; r.now = now; r.n_typed = -1; r.typed = '0;
        return r;
    endfunction

    function automatic t_row typed(t_row r, int n, t_expiry e);
        r.n_typed = n; r.typed = e;
        return r;
    endfunction

    // output side: random stall, check at rising edge
    initial begin
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 19) < 2) begin
                i_stall = 1'b1;
                repeat (gap()) @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall = 1'b1;
                @(negedge i_clk);
            end
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_expired_id, o_due_time, o_is_periodic, o_last_expiry};
            if (expected_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected expiry word %p", got);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (got != want) begin
                    if (mismatches < 10)
                        $display("expiry mismatch: expected %p, got %p", want, got);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_row    r;
        int      kind, id;
        t_time   iv;
        i_rst_n = 1'b0; i_valid = 1'b0; i_req_type = REQ_TICK; i_timer_id = '0;
        i_interval = '0; i_time_now = '0;
        mismatches = 0;
        q_count = 0; tick_skip = 1'b1;
        foreach (q_order[i]) begin
            q_order[i] = '0; due_of[i] = '0; period_of[i] = '0; armed[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        rows.push_back(mk(REQ_ADD_ONE, 3, 0, 0));
        rows.push_back(typed(mk(REQ_TICK, 9, 32'hFFFF_FFFF, 100), 0, '0)); // first tick idle
        rows.push_back(typed(mk(REQ_TICK, 0, 0, 1), 1, '{4'd3, 32'd1, 1'b0, 1'b1}));
        rows.push_back(mk(REQ_ADD_PER, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(mk(REQ_ADD_ONE, 0, 10, 0));
        rows.push_back(mk(REQ_ADD_ONE, 1, 10, 0));    // tie after slot 0
        rows.push_back(mk(REQ_ADD_PER, 2, 5, 0));
        rows.push_back(mk(REQ_ADD_ONE, 1, 7, 0));     // re-add armed
        rows.push_back(mk(REQ_DELETE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(mk(REQ_DELETE, 9, 0, 0));      // delete unarmed
        rows.push_back(mk(REQ_TICK, 0, 0, 20));
        rows.push_back(mk(REQ_ADD_PER, 4, 32'h8000_0000, 20)); // half range period
        rows.push_back(mk(REQ_TICK, 0, 0, 32'h8000_0014));
        rows.push_back(mk(REQ_TICK, 0, 0, 32'h8000_0014));
        for (int i = 0; i < SLOTS; i++) rows.push_back(mk(REQ_ADD_PER, i, 1, 32'hFFFF_FFF0));
        rows.push_back(mk(REQ_TICK, 0, 0, 32'h0000_0005)); // all sixteen, across wrap
        foreach (rows[i]) send(rows[i]);

        clock_now = 32'h10;
        for (int n = 0; n < 300; n++) begin
            kind = $urandom_range(0, 9);
            id = $urandom_range(0, SLOTS - 1);
            case ($urandom_range(0, 5))
                0: iv = '0;
                1: iv = $urandom();
                2: iv = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: iv = $urandom_range(1, 40);
            endcase
            if (kind < 3) r = mk(REQ_ADD_ONE, id, iv, clock_now);
            else if (kind < 5) r = mk(REQ_ADD_PER, id, iv, clock_now);
            else if (kind < 6) r = mk(REQ_DELETE, id, $urandom(), $urandom());
            else begin
                clock_now += ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 12);
                r = mk(REQ_TICK, $urandom_range(0, SLOTS - 1), $urandom(), clock_now);
            end
            send(r);
        end

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
